/* rtl/cfr_pkg.sv */
// Package with shared widths, codes and types of the covariance block.
`default_nettype none
package cfr_pkg;

   localparam int RES_W          = 16;
   localparam int COV_W          = 41;
   localparam int IDX_W          = 3;
   localparam int STATUS_W       = 2;
   localparam int CFG_W          = 4;
   localparam int NUM_RES        = 8;
   localparam int REQ_DATA_W     = NUM_RES * RES_W;
   localparam int RSP_FIELD_W    = 2 * IDX_W + COV_W + STATUS_W;
   localparam int RSP_DATA_W     = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int DEF_MAX_SETS   = 8;
   localparam int DEF_MAX_POINTS = 1024;
   localparam logic [CFG_W-1:0] NUM_SETS_RESET = 4'd8;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FEW     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_DRAIN,
      ST_EMIT_RD,
      ST_DIV_GO,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

/* rtl/cfr_div.sv */
// Serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
`default_nettype none
module cfr_div #(
   parameter int DVD_W = 42,
   parameter int DVS_W = 11
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DVD_W-1:0]      dividend,
   input  wire logic [DVS_W-1:0]      divisor,
   output cfr_pkg::div_status_type    status,
   output logic      [DVD_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_sh;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = CNT_W'(DVD_W);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : DVS_W'(rem_sh);
         quo_in  = {quo_ff[DVD_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule
`default_nettype wire

/* rtl/covariance_from_residuals.sv */
// Top level: sample covariance matrix accumulated from residual rows.
//
//  channel | direction | payload
//  req_    | in        | tdata: residual_0..residual_7 (16 b each), tlast: last_row
//  rsp_    | out       | tdata: row_index, col_index, covariance, status; tlast: last_entry
//  csr_    | in        | data: num_sets (4 b), always ready
//
// A row is accumulated as one read-modify-write of one accumulator row per
// cycle through the sum memory (one read and one write port), eight multipliers wide,
// followed by one drain state.
// Each emitted entry is formed by the serial divider, one entry at a time.
// Reset clears the control state and the row valid bits, which stand for zero sums.
// A stalled result channel holds the emission; the next row is taken while the final
// entry still waits in the output register.
`default_nettype none
module covariance_from_residuals #(
   parameter int MAX_SETS   = cfr_pkg::DEF_MAX_SETS,
   parameter int MAX_POINTS = cfr_pkg::DEF_MAX_POINTS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // residual_0 .. residual_7, lowest bits first
   input  wire logic [cfr_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                            req_tlast,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // row_index[2:0], col_index[5:3], covariance[46:6], status[48:47], zero fill
   output logic [cfr_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [cfr_pkg::CFG_W-1:0]       csr_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready
);

   localparam int SET_W = $clog2(MAX_SETS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int PRD_W = 2 * cfr_pkg::RES_W;
   // Magnitude of any product stays within 2^30, so a sum of MAX_POINTS of them fits.
   localparam int SUM_W = PRD_W + $clog2(MAX_POINTS);
   localparam int CMP_W = (SUM_W > cfr_pkg::COV_W + 1) ? SUM_W : cfr_pkg::COV_W + 1;
   localparam logic [CMP_W-1:0] POS_LIM = CMP_W'((64'd1 << (cfr_pkg::COV_W - 1)) - 1);
   localparam logic [CMP_W-1:0] NEG_LIM = CMP_W'(64'd1 << (cfr_pkg::COV_W - 1));

   typedef logic [MAX_SETS-1:0][SUM_W-1:0] row_type;

   // Configuration register.
   logic [cfr_pkg::CFG_W-1:0] num_sets_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_sets_ff <= cfr_pkg::NUM_SETS_RESET;
      end else if (csr_valid) begin
         num_sets_ff <= csr_data;
      end
   end

   // The effective matrix size clamps zero up to one and large values to MAX_SETS.
   logic [SET_W-1:0] last_idx;
   always_comb begin
      if (num_sets_ff == '0) begin
         last_idx = '0;
      end else if (num_sets_ff > cfr_pkg::CFG_W'(MAX_SETS)) begin
         last_idx = SET_W'(MAX_SETS - 1);
      end else begin
         last_idx = SET_W'(num_sets_ff - 1'b1);
      end
   end

   cfr_pkg::state_type state_ff, state_in;

   logic signed [cfr_pkg::RES_W-1:0] res_ff [MAX_SETS];
   logic                            last_ff;
   logic [CNT_W-1:0]                row_count_ff, row_count_in;
   logic                            overflow_ff, overflow_in;
   logic [SET_W-1:0]                idx_i_ff, idx_i_in;
   logic [SET_W-1:0]                idx_j_ff, idx_j_in;
   logic                            clear_sums;

   // Sum memory: one row of MAX_SETS sums per entry, valid bits stand for zero rows.
   row_type                 mem_ff [MAX_SETS];
   logic [MAX_SETS-1:0]     row_valid_ff;
   row_type                 rd_ff;
   logic                    rd_valid_ff;
   logic                    rd_en;
   logic [SET_W-1:0]        rd_addr;
   logic                    wr_pend_ff;
   logic [SET_W-1:0]        wr_addr_ff;
   logic signed [PRD_W-1:0] prod_ff [MAX_SETS];
   row_type                 wr_row;
   row_type                 rd_row;

   always_comb begin
      for (int j = 0; j < MAX_SETS; j++) begin
         rd_row[j] = rd_valid_ff ? rd_ff[j] : '0;
         wr_row[j] = rd_row[j] + {{(SUM_W - PRD_W){prod_ff[j][PRD_W-1]}}, prod_ff[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff       <= mem_ff[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
      if (wr_pend_ff) begin
         mem_ff[wr_addr_ff] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_sums) begin
         row_valid_ff <= '0;
      end else if (wr_pend_ff) begin
         row_valid_ff[wr_addr_ff] <= 1'b1;
      end
   end

   // Multiply stage: one accumulator row per cycle, written back in the next cycle.
   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_SETS; j++) begin
         prod_ff[j] <= res_ff[idx_i_ff] * res_ff[j];
      end
      wr_addr_ff <= idx_i_ff;
      if (reset) begin
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= (state_ff == cfr_pkg::ST_ACC);
      end
   end

   // Divider for the entry being emitted.
   cfr_pkg::div_status_type div_status;
   logic                    div_start;
   logic [SUM_W-1:0]        div_mag;
   logic [SUM_W-1:0]        div_quo;
   logic                    neg_ff, neg_in;
   logic [SUM_W-1:0]        lane_sum;
   logic [CNT_W-1:0]        divisor;

   assign lane_sum = rd_row[idx_j_ff];
   assign div_mag  = lane_sum[SUM_W-1] ? SUM_W'(-lane_sum) : lane_sum;
   assign divisor  = row_count_ff - 1'b1;

   cfr_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_mag),
      .divisor  (divisor),
      .status   (div_status),
      .quotient (div_quo)
   );

   // Saturate the quotient into the covariance field, apply the sign, set the status.
   logic [CMP_W-1:0]             quo_wide;
   logic [CMP_W-1:0]             neg_wide;
   logic [cfr_pkg::COV_W-1:0]    cov_val;
   logic [cfr_pkg::STATUS_W-1:0] status_val;
   logic                         few_rows;

   always_comb begin
      quo_wide = CMP_W'(div_quo);
      neg_wide = -quo_wide;
      few_rows = row_count_ff < CNT_W'(2);
      if (few_rows) begin
         cov_val = '0;
      end else if (neg_ff) begin
         cov_val = (quo_wide > NEG_LIM) ? cfr_pkg::COV_W'(NEG_LIM)
                                        : neg_wide[cfr_pkg::COV_W-1:0];
      end else begin
         cov_val = (quo_wide > POS_LIM) ? POS_LIM[cfr_pkg::COV_W-1:0]
                                        : quo_wide[cfr_pkg::COV_W-1:0];
      end
      if (few_rows) begin
         status_val = cfr_pkg::STATUS_FEW;
      end else if (overflow_ff) begin
         status_val = cfr_pkg::STATUS_DROPPED;
      end else begin
         status_val = cfr_pkg::STATUS_OK;
      end
   end

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_last_ff;
   logic [cfr_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                          rsp_free;
   logic                          rsp_load;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= cfr_pkg::RSP_DATA_W'({status_val, cov_val,
                                              cfr_pkg::IDX_W'(idx_j_ff),
                                              cfr_pkg::IDX_W'(idx_i_ff)});
         rsp_last_ff <= (idx_i_ff == last_idx) && (idx_j_ff == last_idx);
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequencer.
   logic req_take;
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      row_count_in = row_count_ff;
      overflow_in  = overflow_ff;
      idx_i_in     = idx_i_ff;
      idx_j_in     = idx_j_ff;
      neg_in       = neg_ff;
      req_tready   = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = idx_i_ff;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      clear_sums   = 1'b0;
      unique case (state_ff)
         cfr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            idx_i_in   = '0;
            idx_j_in   = '0;
            if (req_take) begin
               if (row_count_ff >= CNT_W'(MAX_POINTS)) begin
                  overflow_in = 1'b1;
                  state_in    = req_tlast ? cfr_pkg::ST_EMIT_RD : cfr_pkg::ST_IDLE;
               end else begin
                  row_count_in = row_count_ff + 1'b1;
                  state_in     = cfr_pkg::ST_ACC;
               end
            end
         end
         cfr_pkg::ST_ACC: begin
            rd_en    = 1'b1;
            idx_i_in = idx_i_ff + 1'b1;
            if (idx_i_ff == SET_W'(MAX_SETS - 1)) begin
               idx_i_in = '0;
               state_in = cfr_pkg::ST_DRAIN;
            end
         end
         cfr_pkg::ST_DRAIN: begin
            state_in = last_ff ? cfr_pkg::ST_EMIT_RD : cfr_pkg::ST_IDLE;
         end
         cfr_pkg::ST_EMIT_RD: begin
            rd_en    = 1'b1;
            idx_j_in = '0;
            state_in = cfr_pkg::ST_DIV_GO;
         end
         cfr_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            neg_in    = lane_sum[SUM_W-1];
            state_in  = cfr_pkg::ST_DIV;
         end
         cfr_pkg::ST_DIV: begin
            if (div_status.done) begin
               state_in = cfr_pkg::ST_OUT;
            end
         end
         cfr_pkg::ST_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (idx_j_ff != last_idx) begin
                  idx_j_in = idx_j_ff + 1'b1;
                  state_in = cfr_pkg::ST_DIV_GO;
               end else if (idx_i_ff != last_idx) begin
                  idx_i_in = idx_i_ff + 1'b1;
                  state_in = cfr_pkg::ST_EMIT_RD;
               end else begin
                  clear_sums   = 1'b1;
                  row_count_in = '0;
                  overflow_in  = 1'b0;
                  state_in     = cfr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = cfr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int j = 0; j < MAX_SETS; j++) begin
            res_ff[j] <= req_tdata[j*cfr_pkg::RES_W +: cfr_pkg::RES_W];
         end
         last_ff <= req_tlast;
      end
      neg_ff <= neg_in;
      if (reset) begin
         state_ff     <= cfr_pkg::ST_IDLE;
         row_count_ff <= '0;
         overflow_ff  <= 1'b0;
         idx_i_ff     <= '0;
         idx_j_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         overflow_ff  <= overflow_in;
         idx_i_ff     <= idx_i_in;
         idx_j_ff     <= idx_j_in;
      end
   end

`ifndef ASSERT_OFF
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= CNT_W'(MAX_POINTS))
      else $error("row count beyond its limit");

   a_no_write_in_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cfr_pkg::ST_DIV_GO || state_ff == cfr_pkg::ST_OUT) |-> !wr_pend_ff)
      else $error("sum write during emission");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      clear_sums |=> (row_count_ff == '0) && (row_valid_ff == '0) && !overflow_ff)
      else $error("sums not cleared after the final entry");
`endif

endmodule
`default_nettype wire
